// ----- design/tpte_pkg.sv -----
`timescale 1ns / 1ps
package tpte_pkg;

  localparam int NUM_TABLES = 16;
  localparam int IDX_W      = 10;
  localparam int SLOT_W     = $clog2(NUM_TABLES);
  localparam int USED_W     = $clog2(NUM_TABLES + 1);
  localparam int TBL_AW     = SLOT_W + IDX_W;
  localparam int PFN_W      = 20;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;
  localparam int BIT_LARGE   = 7;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_SETFL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_OOM      = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FAIL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PDE,
    ST_PTE,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr_in;
    logic [2:0]  access_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys_addr_out;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] di;
    logic [IDX_W-1:0] ti;
    logic [21:0]      offset;
    logic [PFN_W-1:0] frame;
    logic [1:0]       acc;
  } cmd_t;

endpackage

// ----- design/tpte_front.sv -----
`timescale 1ns / 1ps
module tpte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tpte_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output tpte_pkg::cmd_t    cmd_o
);
  import tpte_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.op     = op_e'(in_item_i.opcode);
    cmd_new.di     = in_item_i.virt_addr[31:22];
    cmd_new.ti     = in_item_i.virt_addr[21:12];
    cmd_new.offset = in_item_i.virt_addr[21:0];
    cmd_new.frame  = in_item_i.phys_addr_in[31:12];
    cmd_new.acc    = {in_item_i.access_flags[BIT_USER], in_item_i.access_flags[BIT_WRITE]};
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

endmodule

// ----- design/tpte_back.sv -----
`timescale 1ns / 1ps
module tpte_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tpte_pkg::PFN_W-1:0]   cfg_data_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  tpte_pkg::cmd_t               cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tpte_pkg::out_item_t          out_item_o
);
  import tpte_pkg::*;

  logic [31:0] dir_mem [1 << IDX_W];
  logic [31:0] tbl_mem [1 << TBL_AW];

  state_e            state_q, state_d;
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] slot_q;
  logic [USED_W-1:0] used_q;
  logic [PFN_W-1:0]  base_q;
  status_e           status_q, status_d;
  logic [31:0]       res_q, res_d;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [31:0]       dir_rd_q, tbl_rd_q;

  logic              dir_we, tbl_we, res_set, alloc, cnt_inc, out_load;
  logic [IDX_W-1:0]  dir_raddr, dir_waddr;
  logic [31:0]       dir_wdata, tbl_wdata, pte_new;
  logic [TBL_AW-1:0] tbl_raddr, tbl_waddr;
  logic [PFN_W-1:0]  t_off, alloc_pfn;
  logic              present, is_large, in_pool, pool_full, out_free, cnt_last;
  logic [SLOT_W-1:0] slot;

  assign present   = dir_rd_q[BIT_PRESENT];
  assign is_large  = dir_rd_q[BIT_LARGE];
  assign t_off     = dir_rd_q[31:12] - base_q;
  assign in_pool   = (t_off < PFN_W'(NUM_TABLES));
  assign slot      = t_off[SLOT_W-1:0];
  assign pool_full = (used_q == USED_W'(NUM_TABLES));
  assign alloc_pfn = base_q + PFN_W'(used_q);
  assign pte_new   = {cmd_q.frame, 9'd0, cmd_q.acc, 1'b1};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cnt_last  = (cnt_q == {IDX_W{1'b1}});
  assign dir_raddr = (state_q == ST_IDLE) ? cmd_i.di : cmd_q.di;
  assign tbl_raddr = {slot, cmd_q.ti};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (cnt_last) state_d = ST_IDLE;
      ST_IDLE:  if (cmd_valid_i) state_d = ST_PDE;
      ST_PDE: begin
        if (cmd_q.op == OP_MAP) begin
          state_d = (!present && !pool_full) ? ST_CLEAR : ST_RESP;
        end else if (present && !is_large && in_pool && cmd_q.op != OP_UNMAP) begin
          state_d = ST_PTE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_PTE:   state_d = ST_RESP;
      ST_CLEAR: if (cnt_last) state_d = ST_RESP;
      ST_RESP:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_INIT;
    endcase
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = cmd_q.di;
    dir_wdata = '0;
    tbl_we    = 1'b0;
    tbl_waddr = {slot, cmd_q.ti};
    tbl_wdata = '0;
    res_set   = 1'b0;
    status_d  = STS_OK;
    res_d     = '0;
    alloc     = 1'b0;
    cnt_inc   = 1'b0;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = cnt_q;
        cnt_inc   = 1'b1;
      end
      ST_IDLE: cmd_pop_o = cmd_valid_i;
      ST_PDE: begin
        res_set = 1'b1;
        if (cmd_q.op == OP_MAP) begin
          if (!present) begin
            if (pool_full) begin
              status_d = STS_OOM;
            end else begin
              alloc     = 1'b1;
              dir_we    = 1'b1;
              dir_wdata = {alloc_pfn, 9'd0, cmd_q.acc, 1'b1};
            end
          end else if (is_large || !in_pool) begin
            status_d = STS_FAIL;
          end else begin
            tbl_we    = 1'b1;
            tbl_wdata = pte_new;
          end
        end else if (!present) begin
          status_d = STS_NOTFOUND;
        end else if (is_large) begin
          if (cmd_q.op == OP_XLATE) res_d = {dir_rd_q[31:22], cmd_q.offset};
          else status_d = STS_FAIL;
        end else if (!in_pool) begin
          status_d = STS_FAIL;
        end else if (cmd_q.op == OP_UNMAP) begin
          tbl_we = 1'b1;
        end
      end
      ST_PTE: begin
        res_set   = 1'b1;
        tbl_waddr = {slot_q, cmd_q.ti};
        tbl_wdata = {tbl_rd_q[31:12], 9'd0, cmd_q.acc, 1'b1};
        if (!tbl_rd_q[BIT_PRESENT]) begin
          status_d = STS_NOTFOUND;
        end else if (cmd_q.op == OP_XLATE) begin
          res_d = {tbl_rd_q[31:12], cmd_q.offset[11:0]};
        end else begin
          tbl_we = 1'b1;
        end
      end
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {slot_q, cnt_q};
        tbl_wdata = (cnt_q == cmd_q.ti) ? pte_new : 32'd0;
        cnt_inc   = 1'b1;
      end
      ST_RESP:  out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      used_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) base_q <= cfg_data_i;
      if (alloc) begin
        used_q <= used_q + USED_W'(1);
        cnt_q  <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (state_q == ST_PDE) slot_q <= alloc ? used_q[SLOT_W-1:0] : slot;
    if (res_set) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
    if (out_load) begin
      out_q.status        <= status_q;
      out_q.phys_addr_out <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rd_q <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- design/two_level_page_table_engine.sv -----
`timescale 1ns / 1ps
// Two-level page table engine with a 1024-entry directory and a pool of tables.
// Each input item carries an operation (map, unmap, translate, set flags), a
// virtual address, a physical address and access flags. Each item produces
// exactly one output item with a status and a translated address.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The configuration write sets the pool base page at once.
// An item goes through the engine with a directory read only, or with a
// directory read and then a table entry read, as the two memory reads are
// dependent. A map that allocates a table clears that table one entry per cycle.
// After reset the engine clears the directory; the input queue can take two
// items during that time, and the engine starts afterwards.
// While the receiver stalls, the output register holds its item and the engine
// waits with the next result, and the two-entry input queue fills and stalls.
module two_level_page_table_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tpte_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tpte_pkg::out_item_t        out_item_o,
  input  logic                       cfg_we_i,
  input  logic [tpte_pkg::PFN_W-1:0] cfg_data_i
);
  import tpte_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  tpte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  tpte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- design/tpte_checker.sv -----
`timescale 1ns / 1ps
module tpte_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tpte_pkg::out_item_t out_item_o
);
  import tpte_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed under stall");

  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.phys_addr_out != 32'd0 |-> out_item_o.status == STS_OK)
    else $error("address returned with an error status");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind two_level_page_table_engine tpte_checker u_chk (.*);
